// ----- hw/rtl/dual_plane_crc32c_witness_top_assert.svh -----
// assertion macros for the dual-plane crc-32c witness block
`ifndef DUAL_PLANE_CRC32C_WITNESS_TOP_ASSERT_SVH
`define DUAL_PLANE_CRC32C_WITNESS_TOP_ASSERT_SVH

// next-cycle implication, off while reset is held
`define DPCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("dpcw assertion failed");

// next-cycle implication that also watches the reset cycles
`define DPCW_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("dpcw assertion failed");

`endif

// ----- hw/rtl/dpcw_pkg.sv -----
// shared types, constants and update functions of the dual-plane crc-32c witness
package dpcw_pkg;

  localparam logic [31:0] CrcPoly  = 32'h82F6_3B78;
  localparam logic [31:0] CrcInit  = 32'hFFFF_FFFF;
  localparam logic [31:0] FoldInit = 32'h0000_0000;

  localparam logic ModeFold = 1'b0;
  localparam logic ModeCrc  = 1'b1;
  localparam logic ModeReset = ModeCrc;

  typedef struct packed {
    logic [7:0]  hi_byte;
    logic [7:0]  lo_byte;
    logic        last;
    logic [31:0] expected_witness;
  } in_item_t;

  typedef struct packed {
    logic [31:0] witness;
    logic        matches_res;
  } out_item_t;

  // what one lane hands to the merge stage
  typedef struct packed {
    logic [31:0] crc;
    logic [31:0] fold;
  } lane_sum_t;

  // reflected crc-32c, one byte, bit at a time
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  // xor the byte in, then rotate left by one
  function automatic logic [31:0] fold_byte(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] a;
    a = acc ^ {24'd0, b};
    return {a[30:0], a[31]};
  endfunction

endpackage

// ----- hw/rtl/dpcw_lane.sv -----
// one plane lane: running crc-32c and rotate-xor fold over that plane's bytes
module dpcw_lane (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic              last,
  input  logic [7:0]        data_byte,
  output dpcw_pkg::lane_sum_t sum
);

  logic [31:0] crc_r, crc_nxt;
  logic [31:0] fold_r, fold_nxt;
  logic [31:0] crc_upd, fold_upd;

  assign crc_upd  = dpcw_pkg::crc_byte(crc_r, data_byte);
  assign fold_upd = dpcw_pkg::fold_byte(fold_r, data_byte);

  // sum includes the current word's byte
  assign sum.crc  = crc_upd;
  assign sum.fold = fold_upd;

  always_comb begin
    crc_nxt  = crc_r;
    fold_nxt = fold_r;
    if (fire) begin
      if (last) begin
        crc_nxt  = dpcw_pkg::CrcInit;
        fold_nxt = dpcw_pkg::FoldInit;
      end else begin
        crc_nxt  = crc_upd;
        fold_nxt = fold_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r  <= dpcw_pkg::CrcInit;
      fold_r <= dpcw_pkg::FoldInit;
    end else begin
      crc_r  <= crc_nxt;
      fold_r <= fold_nxt;
    end
  end

endmodule

// ----- hw/rtl/dpcw_merge.sv -----
// merge stage: combines both lanes into the witness and holds the result word
module dpcw_merge (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  logic                 last,
  input  logic                 mode,
  input  logic [31:0]          expected_witness,
  input  dpcw_pkg::lane_sum_t  hi_sum,
  input  dpcw_pkg::lane_sum_t  lo_sum,
  input  logic                 out_ready,
  output logic                 slot_free,
  output logic                 out_valid,
  output dpcw_pkg::out_item_t  out_item
);

  logic                valid_r, valid_nxt;
  dpcw_pkg::out_item_t item_r, item_nxt;
  logic [31:0]         witness;

  // the final complements cancel in the xor of the two crcs
  assign witness = (mode == dpcw_pkg::ModeCrc) ? (hi_sum.crc ^ lo_sum.crc)
                                                : (hi_sum.fold ^ lo_sum.fold);

  assign slot_free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r && !out_ready;
    item_nxt  = item_r;
    if (fire && last) begin
      valid_nxt            = 1'b1;
      item_nxt.witness     = witness;
      item_nxt.matches_res = (witness == expected_witness);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

// ----- hw/rtl/dual_plane_crc32c_witness_top.sv -----
// top level of the dual-plane crc-32c witness block
//
//   channel | direction | handshake             | payload
//   in_     | in        | in_valid / in_ready   | in_item (hi_byte, lo_byte, last, expected)
//   out_    | out       | out_valid / out_ready | out_item (witness, matches_res)
//   cfg_    | in        | cfg_valid / cfg_ready | cfg_witness_mode
//
// one input word per cycle while in_ready is high; both plane lanes update in the cycle the word is taken
// a last word shows its result in the output register in the next cycle
// in_ready drops only while a result waits and out_ready is low
// synchronous active-low reset: mode back to crc, lanes back to their initial values
// cfg_ready is always high; the new mode applies from the next word on
module dual_plane_crc32c_witness_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dpcw_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dpcw_pkg::out_item_t  out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_witness_mode
);

  logic                mode_r, mode_nxt;
  logic                fire;
  logic                slot_free;
  dpcw_pkg::lane_sum_t hi_sum, lo_sum;

  assign cfg_ready = 1'b1;
  assign in_ready  = slot_free;
  assign fire      = in_valid && slot_free;

  assign mode_nxt = (cfg_valid && cfg_ready) ? cfg_witness_mode : mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= dpcw_pkg::ModeReset;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  dpcw_lane u_lane_hi (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .last      (in_item.last),
    .data_byte (in_item.hi_byte),
    .sum       (hi_sum)
  );

  dpcw_lane u_lane_lo (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .last      (in_item.last),
    .data_byte (in_item.lo_byte),
    .sum       (lo_sum)
  );

  dpcw_merge u_merge (
    .clk              (clk),
    .rst_n            (rst_n),
    .fire             (fire),
    .last             (in_item.last),
    .mode             (mode_r),
    .expected_witness (in_item.expected_witness),
    .hi_sum           (hi_sum),
    .lo_sum           (lo_sum),
    .out_ready        (out_ready),
    .slot_free        (slot_free),
    .out_valid        (out_valid),
    .out_item         (out_item)
  );

endmodule

// ----- hw/rtl/dpcw_checker.sv -----
// port-level checks of the dual-plane crc-32c witness block, bound to the top level
`include "dual_plane_crc32c_witness_top_assert.svh"

module dpcw_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input dpcw_pkg::in_item_t  in_item,
  input logic                out_valid,
  input logic                out_ready,
  input dpcw_pkg::out_item_t out_item
);

  logic in_fire;
  logic out_fire;
  logic last_fire;

  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign last_fire = in_fire && in_item.last;

  // a waiting result word holds
  `DPCW_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_item))

  // no result word straight after reset
  `DPCW_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid)

  // a last word always yields a result word in the next cycle
  `DPCW_ASSERT_NEXT(a_last_result, clk, rst_n, last_fire, out_valid)

  // a word that is not last yields nothing, and a drained slot empties
  `DPCW_ASSERT_NEXT(a_no_extra, clk, rst_n, (out_fire || !out_valid) && !last_fire, !out_valid)

endmodule

bind dual_plane_crc32c_witness_top dpcw_checker u_dpcw_checker (.*);
